// ===== rtl/core/bim_pkg.sv =====
// Shared constants, types and helpers for the Bernstein interval basis matrix.
`default_nettype none

package bim_pkg;

  localparam int MAX_DEGREE = 7;
  localparam int FRAC_BITS  = 24;

  localparam int DEG_W  = 3;
  localparam int PAR_W  = 25;
  localparam int OUT_W  = 30;
  localparam int VAL_W  = FRAC_BITS + 1;
  localparam int ACC_W  = 2 * FRAC_BITS + 4;
  localparam int RND_W  = ACC_W - FRAC_BITS;
  localparam int BIN_W  = 6;
  localparam int ADDR_W = 1 + 2 * DEG_W;

  localparam logic [VAL_W-1:0] ONE  = VAL_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  // binomial coefficients C(n,k), row n, column k
  localparam logic [BIN_W-1:0] BINOM [8][8] = '{
    '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
    '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
    '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
    '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
  };

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_CLEAR,
    MAC_LOAD,
    MAC_ADD
  } mac_op_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [RND_W-1:0] round_fx(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] s;
    s = acc + HALF;
    return s[ACC_W-1:FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bernstein_interval_basis_matrix.sv =====
// The matrix has N = (d+1)^2 entries, all computed one after another on the one shared MAC.
// Throughput: one request at a time; in_ready_o is high only while idle.
// Entries stream out through an output register and are held while out_ready_i is low.
// Reset: rst_ni is asynchronous, active low; clears sequencer and output valid.
// Triangle memory needs no clearing: every entry is written before its value is used.
`default_nettype none

module bernstein_interval_basis_matrix (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [bim_pkg::DEG_W-1:0]   poly_degree_i,
  input  wire logic [bim_pkg::PAR_W-1:0]   seg_start_i,
  input  wire logic [bim_pkg::PAR_W-1:0]   seg_end_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [bim_pkg::DEG_W-1:0]        row_index_o,
  output logic [bim_pkg::DEG_W-1:0]        col_index_o,
  output logic [bim_pkg::OUT_W-1:0]        entry_value_o,
  output logic                             last_entry_o
);

  localparam int DW = bim_pkg::DEG_W;
  localparam logic [DW-1:0] Idx1 = DW'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT0,
    S_INIT1,
    S_TRI_A,
    S_TRI_B,
    S_TRI_C,
    S_TRI_W,
    S_ENT_INIT,
    S_ENT_A,
    S_ENT_B,
    S_ENT_C,
    S_ENT_R,
    S_ENT_S,
    S_ENT_O
  } state_e;

  state_e                     state_q;
  logic [DW-1:0]              d_q, r_q, m_q, i_q, j_q, k_q;
  logic                       sel_q;
  logic [bim_pkg::VAL_W-1:0]  ts_q, te_q, s_q;
  logic [bim_pkg::RND_W-1:0]  v_q;
  logic                       out_valid_q, last_q;
  logic [DW-1:0]              row_q, col_q;
  logic [bim_pkg::OUT_W-1:0]  value_q;

  bim_pkg::mem_req_t          mem_req;
  logic [bim_pkg::VAL_W-1:0]  rdata;
  bim_pkg::mac_op_e           mac_op;
  logic [bim_pkg::RND_W-1:0]  mac_a;
  logic [bim_pkg::VAL_W-1:0]  mac_b;
  logic [bim_pkg::ACC_W-1:0]  acc;

  logic [bim_pkg::VAL_W-1:0]  t_sel, u_sel, ts_c, te_c, tri_val;
  logic [bim_pkg::RND_W-1:0]  rnd;
  logic [DW-1:0]              deg_c, klo, khi;
  logic [DW:0]                ij_sum;
  logic                       ovf, out_free, out_valid_d;

  bim_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  bim_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  assign deg_c = (poly_degree_i > DW'(bim_pkg::MAX_DEGREE)) ? DW'(bim_pkg::MAX_DEGREE)
                                                           : poly_degree_i;
  assign ts_c  = (32'(seg_start_i) > 32'(bim_pkg::ONE)) ? bim_pkg::ONE
                                                        : bim_pkg::VAL_W'(seg_start_i);
  assign te_c  = (32'(seg_end_i) > 32'(bim_pkg::ONE)) ? bim_pkg::ONE
                                                      : bim_pkg::VAL_W'(seg_end_i);

  assign t_sel   = sel_q ? te_q : ts_q;
  assign u_sel   = bim_pkg::ONE - t_sel;
  assign rnd     = bim_pkg::round_fx(acc);
  assign tri_val = (rnd > bim_pkg::RND_W'(bim_pkg::ONE)) ? bim_pkg::ONE
                                                         : bim_pkg::VAL_W'(rnd);

  assign ij_sum  = {1'b0, i_q} + {1'b0, j_q};
  assign klo     = (ij_sum > {1'b0, d_q}) ? DW'(ij_sum - {1'b0, d_q}) : '0;
  assign khi     = (i_q < j_q) ? i_q : j_q;

  assign ovf         = |(acc >> bim_pkg::OUT_W);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_d = ((state_q == S_ENT_O) && out_free) || (out_valid_q && !out_ready_i);

  always_comb begin
    mem_req = '0;
    mac_op  = bim_pkg::MAC_HOLD;
    mac_a   = '0;
    mac_b   = '0;
    unique case (state_q)
      S_INIT0: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {1'b0, DW'(0), DW'(0)};
        mem_req.wdata = bim_pkg::ONE;
      end
      S_INIT1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {1'b1, DW'(0), DW'(0)};
        mem_req.wdata = bim_pkg::ONE;
      end
      S_TRI_A: begin
        mem_req.raddr = {sel_q, r_q - Idx1, m_q - Idx1};
      end
      S_TRI_B: begin
        mem_req.raddr = {sel_q, r_q - Idx1, m_q};
        mac_a         = bim_pkg::RND_W'(t_sel);
        mac_b         = rdata;
        mac_op        = (m_q != '0) ? bim_pkg::MAC_LOAD : bim_pkg::MAC_CLEAR;
      end
      S_TRI_C: begin
        mac_a  = bim_pkg::RND_W'(u_sel);
        mac_b  = rdata;
        mac_op = (m_q < r_q) ? bim_pkg::MAC_ADD : bim_pkg::MAC_HOLD;
      end
      S_TRI_W: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {sel_q, r_q, m_q};
        mem_req.wdata = tri_val;
      end
      S_ENT_INIT: begin
        mac_op = bim_pkg::MAC_CLEAR;
      end
      S_ENT_A: begin
        mem_req.raddr = {1'b0, d_q - j_q, i_q - k_q};
      end
      S_ENT_B: begin
        mem_req.raddr = {1'b1, j_q, k_q};
      end
      S_ENT_C: begin
        mac_a  = bim_pkg::RND_W'(s_q);
        mac_b  = rdata;
        mac_op = bim_pkg::MAC_ADD;
      end
      S_ENT_S: begin
        mac_a  = v_q;
        mac_b  = bim_pkg::VAL_W'(bim_pkg::BINOM[d_q][j_q]);
        mac_op = bim_pkg::MAC_LOAD;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      d_q         <= '0;
      r_q         <= '0;
      m_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      sel_q       <= 1'b0;
      ts_q        <= '0;
      te_q        <= '0;
      s_q         <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      value_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            d_q     <= deg_c;
            ts_q    <= ts_c;
            te_q    <= te_c;
            state_q <= S_INIT0;
          end
        end
        S_INIT0: begin
          state_q <= S_INIT1;
        end
        S_INIT1: begin
          sel_q <= 1'b0;
          r_q   <= Idx1;
          m_q   <= '0;
          i_q   <= '0;
          j_q   <= '0;
          state_q <= (d_q == '0) ? S_ENT_INIT : S_TRI_A;
        end
        S_TRI_A: state_q <= S_TRI_B;
        S_TRI_B: state_q <= S_TRI_C;
        S_TRI_C: state_q <= S_TRI_W;
        S_TRI_W: begin
          state_q <= S_TRI_A;
          if (m_q == r_q) begin
            m_q <= '0;
            if (r_q == d_q) begin
              r_q <= Idx1;
              if (sel_q) begin
                state_q <= S_ENT_INIT;
              end else begin
                sel_q <= 1'b1;
              end
            end else begin
              r_q <= r_q + Idx1;
            end
          end else begin
            m_q <= m_q + Idx1;
          end
        end
        S_ENT_INIT: begin
          k_q     <= klo;
          state_q <= S_ENT_A;
        end
        S_ENT_A: state_q <= S_ENT_B;
        S_ENT_B: begin
          s_q     <= rdata;
          state_q <= S_ENT_C;
        end
        S_ENT_C: begin
          if (k_q == khi) begin
            state_q <= S_ENT_R;
          end else begin
            k_q     <= k_q + Idx1;
            state_q <= S_ENT_A;
          end
        end
        S_ENT_R: begin
          v_q     <= rnd;
          state_q <= S_ENT_S;
        end
        S_ENT_S: state_q <= S_ENT_O;
        S_ENT_O: begin
          if (out_free) begin
            row_q       <= i_q;
            col_q       <= j_q;
            value_q     <= ovf ? '1 : bim_pkg::OUT_W'(acc);
            last_q      <= (i_q == d_q) && (j_q == d_q);
            state_q     <= S_ENT_INIT;
            if (j_q == d_q) begin
              j_q <= '0;
              if (i_q == d_q) begin
                state_q <= S_IDLE;
              end else begin
                i_q <= i_q + Idx1;
              end
            end else begin
              j_q <= j_q + Idx1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign row_index_o   = row_q;
  assign col_index_o   = col_q;
  assign entry_value_o = value_q;
  assign last_entry_o  = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/bim_mem.sv =====
// Triangle storage: one write port, one registered read port.
`default_nettype none

module bim_mem (
  input  wire logic                        clk_i,
  input  wire bim_pkg::mem_req_t           req_i,
  output logic [bim_pkg::VAL_W-1:0]        rdata_o
);

  localparam int Depth = 1 << bim_pkg::ADDR_W;

  logic [bim_pkg::VAL_W-1:0] mem_q [Depth];
  logic [bim_pkg::VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/bim_mac.sv =====
// Shared multiply-accumulate unit.
`default_nettype none

module bim_mac (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bim_pkg::mac_op_e            op_i,
  input  wire logic [bim_pkg::RND_W-1:0]   a_i,
  input  wire logic [bim_pkg::VAL_W-1:0]   b_i,
  output logic [bim_pkg::ACC_W-1:0]        acc_o
);

  localparam int ProdW = bim_pkg::RND_W + bim_pkg::VAL_W;

  logic [ProdW-1:0]          prod;
  logic [bim_pkg::ACC_W-1:0] acc_q, acc_d;

  assign prod = {{bim_pkg::VAL_W{1'b0}}, a_i} * {{bim_pkg::RND_W{1'b0}}, b_i};

  always_comb begin
    unique case (op_i)
      bim_pkg::MAC_HOLD:  acc_d = acc_q;
      bim_pkg::MAC_CLEAR: acc_d = '0;
      bim_pkg::MAC_LOAD:  acc_d = bim_pkg::ACC_W'(prod);
      bim_pkg::MAC_ADD:   acc_d = acc_q + bim_pkg::ACC_W'(prod);
      default:            acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== verif/bernstein_interval_basis_matrix_tb.sv =====
`timescale 1ns / 100ps
// Testbench for bernstein_interval_basis_matrix: random and directed requests, predicted matrix entries.

module bernstein_interval_basis_matrix_tb;

  localparam int unsigned ONE_FX      = 1 << bim_pkg::FRAC_BITS;
  localparam int unsigned PAR_MAX     = (1 << bim_pkg::PAR_W) - 1;
  localparam int          RAND_ITEMS  = 250;
  localparam int          HOLD_AT     = 600;
  localparam int          HOLD_CYCLES = 1500;
  localparam int          IDLE_LIMIT  = 20000;
  localparam int          TAIL_CYCLES = 64;

  typedef bit [63:0] blend_tri_t [8][8];

  typedef struct {
    bit [bim_pkg::DEG_W-1:0] row;
    bit [bim_pkg::DEG_W-1:0] col;
    bit [bim_pkg::OUT_W-1:0] value;
    bit                      last;
  } matrix_entry_t;

  class basis_scoreboard;
    matrix_entry_t entries_q[$];
    int            fail_count;

    function bit [63:0] choose(int n, int k);
      bit [63:0] c;
      c = 64'd1;
      for (int m = 0; m < k; m++) c = c * 64'(n - m) / 64'(m + 1);
      return c;
    endfunction

    function void blend(int d, bit [63:0] t, output blend_tri_t tri_o);
      bit [63:0] acc;
      bit [63:0] v;
      for (int r = 0; r < 8; r++)
        for (int m = 0; m < 8; m++) tri_o[r][m] = 64'd0;
      tri_o[0][0] = 64'(ONE_FX);
      for (int r = 1; r <= d; r++) begin
        for (int m = 0; m <= r; m++) begin
          acc = 0;
          if (m >= 1) acc += t * tri_o[r-1][m-1];
          if (m < r) acc += (64'(ONE_FX) - t) * tri_o[r-1][m];
          v = (acc + (64'd1 << (bim_pkg::FRAC_BITS - 1))) >> bim_pkg::FRAC_BITS;
          tri_o[r][m] = (v > 64'(ONE_FX)) ? 64'(ONE_FX) : v;
        end
      end
    endfunction

    function void note_request(bit [bim_pkg::DEG_W-1:0] deg, bit [bim_pkg::PAR_W-1:0] s,
                               bit [bim_pkg::PAR_W-1:0] e);
      blend_tri_t    s_tri;
      blend_tri_t    e_tri;
      bit [63:0]     ts;
      bit [63:0]     te;
      bit [63:0]     acc;
      bit [63:0]     v;
      int            d;
      int            klo;
      int            khi;
      matrix_entry_t ent;
      d = int'(deg);
      if (d > bim_pkg::MAX_DEGREE) d = bim_pkg::MAX_DEGREE;
      ts = (64'(s) > 64'(ONE_FX)) ? 64'(ONE_FX) : 64'(s);
      te = (64'(e) > 64'(ONE_FX)) ? 64'(ONE_FX) : 64'(e);
      blend(d, ts, s_tri);
      blend(d, te, e_tri);
      for (int i = 0; i <= d; i++) begin
        for (int j = 0; j <= d; j++) begin
          klo = (i + j > d) ? i + j - d : 0;
          khi = (i < j) ? i : j;
          acc = 0;
          for (int k = klo; k <= khi; k++) acc += s_tri[d-j][i-k] * e_tri[j][k];
          v = ((acc + (64'd1 << (bim_pkg::FRAC_BITS - 1))) >> bim_pkg::FRAC_BITS)
              * choose(d, j);
          if (v > (64'd1 << bim_pkg::OUT_W) - 1) v = (64'd1 << bim_pkg::OUT_W) - 1;
          ent.row   = bim_pkg::DEG_W'(i);
          ent.col   = bim_pkg::DEG_W'(j);
          ent.value = v[bim_pkg::OUT_W-1:0];
          ent.last  = (i == d) && (j == d);
          entries_q = {entries_q, ent};
        end
      end
    endfunction

    function void check_entry(bit [bim_pkg::DEG_W-1:0] row, bit [bim_pkg::DEG_W-1:0] col,
                              bit [bim_pkg::OUT_W-1:0] value, bit last);
      matrix_entry_t exp_e;
      if (entries_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected entry: row %0d col %0d value %0h last %0b",
                   row, col, value, last);
        return;
      end
      exp_e = entries_q.pop_front();
      if (exp_e.row != row || exp_e.col != col || exp_e.value != value || exp_e.last != last)
      begin
        fail_count++;
        if (fail_count <= 10)
          $display("entry mismatch: exp (%0d,%0d) %0h last %0b, got (%0d,%0d) %0h last %0b",
                   exp_e.row, exp_e.col, exp_e.value, exp_e.last, row, col, value, last);
      end
    endfunction

    function int pending();
      return entries_q.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [bim_pkg::DEG_W-1:0]    poly_degree_i = '0;
  logic [bim_pkg::PAR_W-1:0]    seg_start_i = '0;
  logic [bim_pkg::PAR_W-1:0]    seg_end_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [bim_pkg::DEG_W-1:0]    row_index_o;
  logic [bim_pkg::DEG_W-1:0]    col_index_o;
  logic [bim_pkg::OUT_W-1:0]    entry_value_o;
  logic                         last_entry_o;

  basis_scoreboard sb;
  int              idle_cycles = 0;
  int              entries_taken = 0;

  bernstein_interval_basis_matrix dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .poly_degree_i,
    .seg_start_i,
    .seg_end_i,
    .out_valid_o,
    .out_ready_i,
    .row_index_o,
    .col_index_o,
    .entry_value_o,
    .last_entry_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(poly_degree_i, seg_start_i, seg_end_i);
      if (out_valid_o && out_ready_i)
        sb.check_entry(row_index_o, col_index_o, entry_value_o, last_entry_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_request(bit [bim_pkg::DEG_W-1:0] deg, bit [bim_pkg::PAR_W-1:0] s,
                              bit [bim_pkg::PAR_W-1:0] e, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    poly_degree_i <= deg;
    seg_start_i   <= s;
    seg_end_i     <= e;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic bit [bim_pkg::PAR_W-1:0] pick_param();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return bim_pkg::PAR_W'(ONE_FX);
      2: return bim_pkg::PAR_W'($urandom_range(ONE_FX + 1, PAR_MAX));
      3: return bim_pkg::PAR_W'($urandom_range(0, PAR_MAX));
      default: return bim_pkg::PAR_W'($urandom_range(0, ONE_FX));
    endcase
  endfunction

  // receiver: random stalls, bursts without stalls, one long hold-off
  initial begin
    int  gap;
    bit  held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (entries_taken >= HOLD_AT && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = ((entries_taken / 64) % 3 == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      entries_taken++;
    end
  end

  initial begin
    int gap;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, reversal, collapsed intervals, clamping, start after end
    send_request(3'd0, 25'd0, bim_pkg::PAR_W'(ONE_FX), 0);
    send_request(3'd7, 25'd0, bim_pkg::PAR_W'(ONE_FX), 0);
    send_request(3'd7, bim_pkg::PAR_W'(ONE_FX), 25'd0, 2);
    send_request(3'd7, 25'd0, 25'd0, 0);
    send_request(3'd7, bim_pkg::PAR_W'(ONE_FX), bim_pkg::PAR_W'(ONE_FX), 1);
    send_request(3'd3, 25'd0, bim_pkg::PAR_W'(ONE_FX / 2), 0);
    send_request(3'd3, bim_pkg::PAR_W'(ONE_FX / 2), bim_pkg::PAR_W'(ONE_FX), 3);
    send_request(3'd7, bim_pkg::PAR_W'(PAR_MAX), bim_pkg::PAR_W'(PAR_MAX), 0);
    send_request(3'd5, bim_pkg::PAR_W'(ONE_FX + 5), bim_pkg::PAR_W'(ONE_FX / 4), 0);
    send_request(3'd4, bim_pkg::PAR_W'(3 * ONE_FX / 4), bim_pkg::PAR_W'(ONE_FX / 4), 5);
    send_request(3'd1, 25'd1, bim_pkg::PAR_W'(ONE_FX - 1), 0);
    send_request(3'd2, 25'h155555, 25'h1AAAAAA, 0);
    send_request(3'd6, 25'h0AAAAAA, 25'h1555555, 7);
    send_request(3'd0, bim_pkg::PAR_W'(PAR_MAX), 25'd0, 0);
    wait_drained();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) wait_drained();
      gap = ((n / 20) % 3 == 0) ? 0 : $urandom_range(0, 7);
      send_request(bim_pkg::DEG_W'($urandom_range(0, 7)), pick_param(), pick_param(), gap);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
